### src/ulw_pkg.sv
// Package for the UTF-8 line wrapper: payload types, byte constants and phase codes.
`timescale 1ns / 1ps
`default_nettype none

package ulw_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COLUMN_W = 9;
    localparam int unsigned PEND_W   = 2;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0]   CR_BYTE = 8'h0D;
    localparam logic [BYTE_W-1:0]   LF_BYTE = 8'h0A;
    localparam logic [COLUMN_W-1:0] COLUMN_MAX = 9'd511;

    localparam logic [BYTE_W-1:0] FIRST_LINE_WIDTH_RST = 8'd80;
    localparam logic [BYTE_W-1:0] OTHER_LINE_WIDTH_RST = 8'd80;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OTHER_LINE_WIDTH = 8'd1;

    // Lead byte classes
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              string_start;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
    } out_t;

    // Which beat of an item the hold stage sends next
    typedef enum logic [1:0] {
        PH_CR,
        PH_LF,
        PH_BYTE
    } phase_t;

endpackage

`default_nettype wire

### src/utf8_line_wrapper.sv
// Top level of the UTF-8 line wrapper: state update, hold stage and output register.
`timescale 1ns / 1ps
`default_nettype none

// utf8_line_wrapper
// Passes a UTF-8 byte stream on and inserts CR LF ahead of a character's lead
// byte once the display column has reached the active line limit.
// Channels:
//   s_   : input beats, payload in_t {text_byte, string_start}.
//   m_   : result beats, payload out_t {out_byte, run_last}; run_last marks the
//          last beat caused by one input byte.
//   cfg_ : register writes; index 0 = first_line_width, 1 = other_line_width.
//          Other indexes are dropped. cfg_ready is always high.
// Timing: the column/continuation state is updated in the cycle a byte is
// accepted; the byte then sits in a hold stage and its beats pass through
// an output register. Throughput is one byte per cycle without wraps while
// the receiver keeps m_ready high; a wrap makes that byte occupy the hold
// stage while it sends CR, LF and then the byte, which stalls s_.
// The hold stage accepts a new byte while the output register still waits
// on a stalled receiver; with both stages full, s_ready drops.
// Reset (aresetn low, synchronous): both stages empty, column and pending
// count zero, first-line flag set, both widths back to 80.
module utf8_line_wrapper
    import ulw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire in_t                  s_data,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      out_t                 m_data,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    // Configuration registers
    logic [BYTE_W-1:0] first_width_reg;
    logic [BYTE_W-1:0] other_width_reg;

    // Line state
    logic [COLUMN_W-1:0] column_reg, column_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic                first_reg, first_next;

    // Hold stage: the accepted byte and whether it wraps
    logic              a_valid_reg, a_valid_next;
    logic [BYTE_W-1:0] a_byte_reg;
    logic              a_wrap_reg;
    phase_t            phase_reg, phase_next;

    // Output register
    logic  m_valid_reg, m_valid_next;
    out_t  m_data_reg, m_data_next;

    logic s_fire;
    logic b_free;
    logic a_last;
    logic wrap_now;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // The output register can take a beat when empty or being drained
    assign b_free = !m_valid_reg || m_ready;
    // Hold stage empties when its byte beat moves to the output register
    assign a_last = a_valid_reg && b_free && (phase_reg == PH_BYTE);
    assign s_ready = !a_valid_reg || a_last;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_width_reg <= FIRST_LINE_WIDTH_RST;
            other_width_reg <= OTHER_LINE_WIDTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FIRST_LINE_WIDTH: first_width_reg <= cfg_data;
                CFG_OTHER_LINE_WIDTH: other_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Line state update for the byte being accepted
    always_comb begin
        logic [COLUMN_W-1:0] col;
        logic [PEND_W-1:0]   pend;
        logic                first;
        logic [BYTE_W-1:0]   limit;
        logic [1:0]          add;
        logic [PEND_W-1:0]   follow;
        logic [COLUMN_W:0]   sum;

        col   = s_data.string_start ? '0 : column_reg;
        pend  = s_data.string_start ? '0 : pend_reg;
        first = s_data.string_start ? 1'b1 : first_reg;
        limit = first ? first_width_reg : other_width_reg;
        wrap_now = 1'b0;
        add    = 2'd1;
        follow = '0;
        sum    = '0;

        if (pend != '0) begin
            pend = pend - 1'b1;
        end else begin
            if (col >= {1'b0, limit}) begin
                wrap_now = 1'b1;
                col   = '0;
                first = 1'b0;
            end
            if ((s_data.text_byte & ASCII_MASK) == ASCII_CODE) begin
                add = 2'd1; follow = 2'd0;
            end else if ((s_data.text_byte & LEAD2_MASK) == LEAD2_CODE) begin
                add = 2'd2; follow = 2'd1;
            end else if ((s_data.text_byte & LEAD3_MASK) == LEAD3_CODE) begin
                add = 2'd2; follow = 2'd2;
            end else if ((s_data.text_byte & LEAD4_MASK) == LEAD4_CODE) begin
                add = 2'd2; follow = 2'd3;
            end else begin
                // Stray continuation or 11111xxx: one column, no followers
                add = 2'd1; follow = 2'd0;
            end
            sum = {1'b0, col} + {{(COLUMN_W-1){1'b0}}, add};
            col = sum[COLUMN_W] ? COLUMN_MAX : sum[COLUMN_W-1:0];
            pend = follow;
        end

        // Any CR sent, inserted or passed, returns to column zero
        if (s_data.text_byte == CR_BYTE) begin
            col = '0;
        end

        column_next = s_fire ? col   : column_reg;
        pend_next   = s_fire ? pend  : pend_reg;
        first_next  = s_fire ? first : first_reg;
    end

    // Phase: next-state logic
    always_comb begin
        phase_next = phase_reg;
        if (s_fire) begin
            phase_next = wrap_now ? PH_CR : PH_BYTE;
        end else if (a_valid_reg && b_free) begin
            case (phase_reg)
                PH_CR:   phase_next = PH_LF;
                PH_LF:   phase_next = PH_BYTE;
                PH_BYTE: phase_next = PH_BYTE;
                default: phase_next = PH_BYTE;
            endcase
        end
    end

    // Phase: beat sent to the output register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        a_valid_next = a_valid_reg;
        if (b_free) begin
            m_valid_next = a_valid_reg;
            case (phase_reg)
                PH_CR:   m_data_next = '{out_byte: CR_BYTE, run_last: 1'b0};
                PH_LF:   m_data_next = '{out_byte: LF_BYTE, run_last: 1'b0};
                PH_BYTE: m_data_next = '{out_byte: a_byte_reg, run_last: 1'b1};
                default: m_data_next = '{out_byte: a_byte_reg, run_last: 1'b1};
            endcase
        end
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_last) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            pend_reg    <= '0;
            first_reg   <= 1'b1;
            a_valid_reg <= 1'b0;
            phase_reg   <= PH_BYTE;
            m_valid_reg <= 1'b0;
        end else begin
            column_reg  <= column_next;
            pend_reg    <= pend_next;
            first_reg   <= first_next;
            a_valid_reg <= a_valid_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_fire) begin
            a_byte_reg <= s_data.text_byte;
            a_wrap_reg <= wrap_now;
        end
    end

    // Column stays within one wide character past an 8-bit limit
    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= 9'd256)
        else $error("column out of range");

    // Inserted CR/LF phases only occur for a wrapping byte in the hold stage
    a_phase_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CR || phase_reg == PH_LF) |-> (a_valid_reg && a_wrap_reg))
        else $error("CR/LF phase without a wrapping byte");

    // A non-final result beat carries an inserted CR or LF
    a_inserted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.run_last) |->
            (m_data_reg.out_byte == CR_BYTE || m_data_reg.out_byte == LF_BYTE))
        else $error("non-final beat is not CR or LF");

    // An inserted CR is followed by the inserted LF as the next beat
    a_cr_then_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !m_data_reg.run_last
            && m_data_reg.out_byte == CR_BYTE)
        |=> (m_valid_reg && !m_data_reg.run_last && m_data_reg.out_byte == LF_BYTE))
        else $error("inserted CR not followed by LF");

endmodule

`default_nettype wire
